[hdl/deq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque package
// Operation and status codes, field widths and default sizes shared by the
// bounded deque core and its element RAM.
// ----------------------------------------------------------------------------
package deq_pkg;

    // Default sizes of the element store.
    localparam int DEQ_CAPACITY  = 256;
    localparam int DEQ_WORD_BITS = 32;

    // Request and result field widths.
    localparam int OP_W     = 4;
    localparam int POS_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    // Stream data widths, rounded up to whole bytes.
    localparam int S_FIELDS_W = OP_W + POS_W + VALUE_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = VALUE_W + STATUS_W + COUNT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 4'd1;
    localparam logic [OP_W-1:0] OP_INSERT     = 4'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 4'd3;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd4;
    localparam logic [OP_W-1:0] OP_REMOVE     = 4'd5;
    localparam logic [OP_W-1:0] OP_READ       = 4'd6;
    localparam logic [OP_W-1:0] OP_WRITE      = 4'd7;
    localparam logic [OP_W-1:0] OP_CLEAR      = 4'd8;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd3;

endpackage

[hdl/bounded_deque_with_indexed_access_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque with indexed access
// Ring-buffer deque of words with push, pop, insert, remove, read, write and
// clear, one result per request.
// ----------------------------------------------------------------------------
// The deque lives in one dual-port RAM of CAPACITY words, addressed as a ring
// from the head slot. One request is worked on at a time and s_tready is high
// only while the core is idle; a finished result sits in the output register,
// so the next request can be taken while that result still waits for
// m_tready. A request that finishes while the earlier result still waits holds
// s_tready low until the output register frees. Pushes, write, clear, no-op
// codes, insert into an empty deque and any request that fails its checks are
// answered from the idle state. Pops and read go through one RAM read first.
// Insert and remove move the elements behind the position one per cycle
// through the RAM's single read and single write port, insert from the back.
// Unknown operation codes return ok with a zero value and leave the deque as
// it is. Clear keeps the head slot.
// ----------------------------------------------------------------------------
module bounded_deque_with_indexed_access_core
    import deq_pkg::*;
#(
    parameter int CAPACITY  = DEQ_CAPACITY,
    parameter int WORD_BITS = DEQ_WORD_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Request channel.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata, from bit 0 up: operation[3:0], position[11:4], value_in[43:12].
    input  logic [S_TDATA_W-1:0] s_tdata,
    // Result channel.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata, from bit 0 up: value_out[31:0], status[33:32], count[42:34].
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_OUT,
        ST_RM_HEAD,
        ST_SHIFT_DN,
        ST_SHIFT_UP,
        ST_PLACE,
        ST_WAIT_OUT
    } state_t;

    // Slot of an element index, counted from the given head slot.
    function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] head,
                                                  input logic [CNT_W-1:0]  idx);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(idx);
        if (sum >= (CNT_W + 1)'(CAPACITY)) begin
            sum = sum - (CNT_W + 1)'(CAPACITY);
        end
        return SLOT_W'(sum);
    endfunction

    // Request fields.
    logic [OP_W-1:0]    in_op;
    logic [POS_W-1:0]   in_pos;
    logic [VALUE_W-1:0] in_value;
    logic [CNT_W-1:0]   in_idx;

    assign in_op    = s_tdata[OP_W-1:0];
    assign in_pos   = s_tdata[OP_W +: POS_W];
    assign in_value = s_tdata[OP_W + POS_W +: VALUE_W];
    assign in_idx   = CNT_W'(in_pos);

    // Registers.
    state_t                state_reg,       state_next;
    logic [SLOT_W-1:0]     head_reg,        head_next;
    logic [CNT_W-1:0]      count_reg,       count_next;
    logic [CNT_W-1:0]      cursor_reg,      cursor_next;
    logic [CNT_W-1:0]      last_reg,        last_next;
    logic [WORD_BITS-1:0]  word_reg,        word_next;
    logic [VALUE_W-1:0]    hold_value_reg,  hold_value_next;
    logic [STATUS_W-1:0]   hold_status_reg, hold_status_next;
    logic                  m_tvalid_reg,    m_tvalid_next;
    logic [VALUE_W-1:0]    m_value_reg,     m_value_next;
    logic [STATUS_W-1:0]   m_status_reg,    m_status_next;
    logic [COUNT_W-1:0]    m_count_reg,     m_count_next;

    // RAM ports.
    logic                  wr_en;
    logic [CNT_W-1:0]      wr_idx;
    logic [SLOT_W-1:0]     wr_addr;
    logic [WORD_BITS-1:0]  wr_data;
    logic                  rd_en;
    logic [CNT_W-1:0]      rd_idx;
    logic [SLOT_W-1:0]     rd_addr;
    logic [WORD_BITS-1:0]  rd_data;

    // Completion of the current request.
    logic                  done;
    logic [VALUE_W-1:0]    done_value;
    logic [STATUS_W-1:0]   done_status;

    logic                  accept;
    logic                  out_free;
    logic                  is_full;
    logic                  is_empty;
    logic                  pos_lt_cnt;
    logic [SLOT_W-1:0]     head_dec;
    logic [SLOT_W-1:0]     head_inc;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign is_full    = (count_reg == CNT_W'(CAPACITY));
    assign is_empty   = (count_reg == '0);
    assign pos_lt_cnt = (CMP_W'(in_pos) < CMP_W'(count_reg));
    assign head_dec   = (head_reg == '0) ? SLOT_W'(CAPACITY - 1) : head_reg - SLOT_W'(1);
    assign head_inc   = (head_reg == SLOT_W'(CAPACITY - 1)) ? '0 : head_reg + SLOT_W'(1);
    assign wr_addr    = slot_of(head_reg, wr_idx);
    assign rd_addr    = slot_of(head_reg, rd_idx);

    deq_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        cursor_next      = cursor_reg;
        last_next        = last_reg;
        word_next        = word_reg;
        hold_value_next  = hold_value_reg;
        hold_status_next = hold_status_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_value_next     = m_value_reg;
        m_status_next    = m_status_reg;
        m_count_next     = m_count_reg;
        wr_en            = 1'b0;
        wr_idx           = '0;
        wr_data          = WORD_BITS'(in_value);
        rd_en            = 1'b0;
        rd_idx           = '0;
        done             = 1'b0;
        done_value       = '0;
        done_status      = STAT_OK;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    done = 1'b1;
                    case (in_op)
                        OP_PUSH_FRONT: begin
                            if (is_full) begin
                                done_status = STAT_FULL;
                            end else begin
                                // Index CAPACITY-1 from the head is the slot before it.
                                wr_en      = 1'b1;
                                wr_idx     = CNT_W'(CAPACITY - 1);
                                head_next  = head_dec;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (is_full) begin
                                done_status = STAT_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                wr_idx     = count_reg;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_INSERT: begin
                            if (!(pos_lt_cnt || (is_empty && in_pos == '0))) begin
                                done_status = STAT_RANGE;
                            end else if (is_full) begin
                                done_status = STAT_FULL;
                            end else if (is_empty) begin
                                wr_en      = 1'b1;
                                wr_idx     = '0;
                                count_next = count_reg + CNT_W'(1);
                            end else begin
                                // Move the tail up one place, starting at the back.
                                done        = 1'b0;
                                rd_en       = 1'b1;
                                rd_idx      = count_reg - CNT_W'(1);
                                cursor_next = count_reg;
                                last_next   = in_idx;
                                word_next   = WORD_BITS'(in_value);
                                count_next  = count_reg + CNT_W'(1);
                                state_next  = ST_SHIFT_UP;
                            end
                        end
                        OP_POP_FRONT: begin
                            if (is_empty) begin
                                done_status = STAT_EMPTY;
                            end else begin
                                done       = 1'b0;
                                rd_en      = 1'b1;
                                rd_idx     = '0;
                                head_next  = head_inc;
                                count_next = count_reg - CNT_W'(1);
                                state_next = ST_READ_OUT;
                            end
                        end
                        OP_POP_BACK: begin
                            if (is_empty) begin
                                done_status = STAT_EMPTY;
                            end else begin
                                done       = 1'b0;
                                rd_en      = 1'b1;
                                rd_idx     = count_reg - CNT_W'(1);
                                count_next = count_reg - CNT_W'(1);
                                state_next = ST_READ_OUT;
                            end
                        end
                        OP_REMOVE: begin
                            if (is_empty) begin
                                done_status = STAT_EMPTY;
                            end else if (!pos_lt_cnt) begin
                                done_status = STAT_RANGE;
                            end else begin
                                done        = 1'b0;
                                rd_en       = 1'b1;
                                rd_idx      = in_idx;
                                cursor_next = in_idx;
                                last_next   = count_reg - CNT_W'(1);
                                count_next  = count_reg - CNT_W'(1);
                                state_next  = ST_RM_HEAD;
                            end
                        end
                        OP_READ: begin
                            if (!pos_lt_cnt) begin
                                done_status = STAT_RANGE;
                            end else begin
                                done       = 1'b0;
                                rd_en      = 1'b1;
                                rd_idx     = in_idx;
                                state_next = ST_READ_OUT;
                            end
                        end
                        OP_WRITE: begin
                            if (!pos_lt_cnt) begin
                                done_status = STAT_RANGE;
                            end else begin
                                wr_en  = 1'b1;
                                wr_idx = in_idx;
                            end
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ_OUT: begin
                done       = 1'b1;
                done_value = VALUE_W'(rd_data);
            end
            ST_RM_HEAD: begin
                hold_value_next = VALUE_W'(rd_data);
                if (cursor_reg == last_reg) begin
                    done       = 1'b1;
                    done_value = VALUE_W'(rd_data);
                end else begin
                    rd_en      = 1'b1;
                    rd_idx     = cursor_reg + CNT_W'(1);
                    state_next = ST_SHIFT_DN;
                end
            end
            ST_SHIFT_DN: begin
                // Element cursor+1 arrives and drops into slot cursor.
                wr_en   = 1'b1;
                wr_idx  = cursor_reg;
                wr_data = rd_data;
                if (cursor_reg + CNT_W'(1) == last_reg) begin
                    done       = 1'b1;
                    done_value = hold_value_reg;
                end else begin
                    rd_en       = 1'b1;
                    rd_idx      = cursor_reg + CNT_W'(2);
                    cursor_next = cursor_reg + CNT_W'(1);
                end
            end
            ST_SHIFT_UP: begin
                // Element cursor-1 arrives and moves up into slot cursor.
                wr_en       = 1'b1;
                wr_idx      = cursor_reg;
                wr_data     = rd_data;
                cursor_next = cursor_reg - CNT_W'(1);
                if (cursor_reg - CNT_W'(1) == last_reg) begin
                    state_next = ST_PLACE;
                end else begin
                    rd_en  = 1'b1;
                    rd_idx = cursor_reg - CNT_W'(2);
                end
            end
            ST_PLACE: begin
                wr_en   = 1'b1;
                wr_idx  = cursor_reg;
                wr_data = word_reg;
                done    = 1'b1;
            end
            ST_WAIT_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_value_next  = hold_value_reg;
                    m_status_next = hold_status_reg;
                    m_count_next  = COUNT_W'(count_reg);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (done) begin
            if (out_free) begin
                m_tvalid_next = 1'b1;
                m_value_next  = done_value;
                m_status_next = done_status;
                m_count_next  = COUNT_W'(count_next);
                state_next    = ST_IDLE;
            end else begin
                hold_value_next  = done_value;
                hold_status_next = done_status;
                state_next       = ST_WAIT_OUT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        cursor_reg      <= cursor_next;
        last_reg        <= last_next;
        word_reg        <= word_next;
        hold_value_reg  <= hold_value_next;
        hold_status_reg <= hold_status_next;
        m_value_reg     <= m_value_next;
        m_status_reg    <= m_status_next;
        m_count_reg     <= m_count_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_count_reg, m_status_reg, m_value_reg};

`ifndef SYNTH
    // The element count never passes the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("deque count above capacity");

    // The RAM is never read and written at the same slot in one cycle.
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_en && rd_en && (wr_addr == rd_addr)))
        else $error("RAM read and write collide on one slot");

    // A held result only waits while the output register is occupied.
    a_wait_needs_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAIT_OUT) |-> m_tvalid_reg)
        else $error("result held while output register is empty");

    // A request taken while the output register is empty either finishes or starts work.
    a_accept_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !m_tvalid_reg) |=> (m_tvalid_reg || !s_tready))
        else $error("accepted request produced no result and no work");
`endif

endmodule

[hdl/deq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque element RAM
// Simple dual-port synchronous RAM: one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module deq_ram
    import deq_pkg::*;
#(
    parameter int  WIDTH = DEQ_WORD_BITS,
    parameter int  DEPTH = DEQ_CAPACITY,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[tb/deque_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque result checker
// Watches the request and result channels of the deque core and keeps its own
// copy of the ring store, head slot and fill level. For every accepted request
// it works out the value, status and count that must come back, and compares
// each accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module deque_result_checker
    import deq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // s_tdata, from bit 0 up: operation, position, value_in.
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata, from bit 0 up: value_out, status, count.
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   mismatches,
    output int                   outstanding,
    output int                   fill_level,
    output int                   results_seen,
    output int                   full_seen,
    output int                   peak_fill
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } deque_result_t;

    deque_result_t      pending_results[$];
    logic [VALUE_W-1:0] ring [DEQ_CAPACITY];
    int                 head_slot   = 0;
    int                 held        = 0;
    int                 pending_cnt = 0;
    int                 errors      = 0;
    int                 checked     = 0;
    int                 full_hits   = 0;
    int                 max_held    = 0;

    assign mismatches   = errors;
    assign outstanding  = pending_cnt;
    assign fill_level   = held;
    assign results_seen = checked;
    assign full_seen    = full_hits;
    assign peak_fill    = max_held;

    function automatic int slot_at(int idx);
        return (head_slot + idx) % DEQ_CAPACITY;
    endfunction

    // Applies one request to the shadow deque and returns the result it gives.
    function automatic deque_result_t apply_request(logic [OP_W-1:0] op,
                                                    logic [POS_W-1:0] pos,
                                                    logic [VALUE_W-1:0] val);
        deque_result_t res;
        int            p;
        int            i;
        p          = pos;
        res.op     = op;
        res.value  = '0;
        res.status = STAT_OK;
        case (op)
            OP_PUSH_FRONT: begin
                if (held >= DEQ_CAPACITY) begin
                    res.status = STAT_FULL;
                end else begin
                    head_slot = (head_slot + DEQ_CAPACITY - 1) % DEQ_CAPACITY;
                    ring[head_slot] = val;
                    held++;
                end
            end
            OP_PUSH_BACK: begin
                if (held >= DEQ_CAPACITY) begin
                    res.status = STAT_FULL;
                end else begin
                    ring[slot_at(held)] = val;
                    held++;
                end
            end
            OP_INSERT: begin
                // The position check wins over the full check.
                if (!(p < held || (held == 0 && p == 0))) begin
                    res.status = STAT_RANGE;
                end else if (held >= DEQ_CAPACITY) begin
                    res.status = STAT_FULL;
                end else begin
                    for (i = held; i > p; i--)
                        ring[slot_at(i)] = ring[slot_at(i - 1)];
                    ring[slot_at(p)] = val;
                    held++;
                end
            end
            OP_POP_FRONT: begin
                if (held == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    res.value = ring[head_slot];
                    head_slot = (head_slot + 1) % DEQ_CAPACITY;
                    held--;
                end
            end
            OP_POP_BACK: begin
                if (held == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    res.value = ring[slot_at(held - 1)];
                    held--;
                end
            end
            OP_REMOVE: begin
                if (held == 0) begin
                    res.status = STAT_EMPTY;
                end else if (p >= held) begin
                    res.status = STAT_RANGE;
                end else begin
                    res.value = ring[slot_at(p)];
                    for (i = p; i + 1 < held; i++)
                        ring[slot_at(i)] = ring[slot_at(i + 1)];
                    held--;
                end
            end
            OP_READ: begin
                if (p >= held) res.status = STAT_RANGE;
                else res.value = ring[slot_at(p)];
            end
            OP_WRITE: begin
                if (p >= held) res.status = STAT_RANGE;
                else ring[slot_at(p)] = val;
            end
            OP_CLEAR: begin
                // The head slot stays where it is.
                held = 0;
            end
            default: begin
            end
        endcase
        res.count = COUNT_W'(held);
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        deque_result_t      exp_res;
        logic [VALUE_W-1:0]  got_value;
        logic [STATUS_W-1:0] got_status;
        logic [COUNT_W-1:0]  got_count;
        if (!aresetn) begin
            head_slot = 0;
            held      = 0;
            pending_results.delete();
        end else begin
            // The result is handled first: it always belongs to an earlier request.
            if (m_tvalid && m_tready) begin
                got_value  = m_tdata[VALUE_W-1:0];
                got_status = m_tdata[VALUE_W +: STATUS_W];
                got_count  = m_tdata[VALUE_W+STATUS_W +: COUNT_W];
                if (pending_results.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%t: result with no request waiting: value %h status %0d count %0d",
                                 $time, got_value, got_status, got_count);
                end else begin
                    exp_res = pending_results.pop_front();
                    checked++;
                    if (got_value !== exp_res.value || got_status !== exp_res.status ||
                        got_count !== exp_res.count) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%t: result %0d (op %0d) expected value %h status %0d count %0d, got value %h status %0d count %0d",
                                     $time, checked, exp_res.op, exp_res.value, exp_res.status,
                                     exp_res.count, got_value, got_status, got_count);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                exp_res = apply_request(s_tdata[OP_W-1:0], s_tdata[OP_W +: POS_W],
                                        s_tdata[OP_W+POS_W +: VALUE_W]);
                pending_results.push_back(exp_res);
                if (exp_res.status == STAT_FULL) full_hits++;
                if (held > max_held) max_held = held;
            end
        end
        pending_cnt = pending_results.size();
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque core testbench
// Drives the deque core with a short directed request list and then with
// phases of random requests that grow, shrink, fill to capacity or mix all
// operations, with random gaps and stalls on both channels. A separate
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    import deq_pkg::*;

    localparam int ITEM_TARGET  = 1150;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 30;

    localparam logic [OP_W-1:0]    OP_LAST_CODE = {OP_W{1'b1}};
    localparam logic [VALUE_W-1:0] WORD_MAX     = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] WORD_MIN     = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] WORD_ONES    = 32'hFFFF_FFFF;
    localparam logic [POS_W-1:0]   POS_LAST     = {POS_W{1'b1}};

    typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED, PH_FILL} phase_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    // s_tdata, from bit 0 up: operation[3:0], position[11:4], value_in[43:12].
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    // m_tdata, from bit 0 up: value_out[31:0], status[33:32], count[42:34].
    logic [M_TDATA_W-1:0] m_tdata;

    int mismatches;
    int outstanding;
    int fill_level;
    int results_seen;
    int full_seen;
    int peak_fill;

    int requests_sent      = 0;
    int back_to_back_left  = 0;
    bit sink_pressure_done = 0;

    bounded_deque_with_indexed_access_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    deque_result_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .fill_level   (fill_level),
        .results_seen (results_seen),
        .full_seen    (full_seen),
        .peak_fill    (peak_fill)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Run timed out after %0d cycles with %0d results outstanding.",
                 cycles, outstanding);
        $display("*** FAILED ***");
        $finish;
    end

    // Idle cycles before the next request: mostly none or a few, now and then
    // a long gap, and stretches of back-to-back requests.
    function automatic int pick_gap();
        int r;
        if (back_to_back_left > 0) begin
            back_to_back_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 10) begin
            back_to_back_left = $urandom_range(30, 100);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_word();
        if ($urandom_range(0, 9) != 0) return $urandom;
        case ($urandom_range(0, 3))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return WORD_ONES;
            default: return '0;
        endcase
    endfunction

    // Mostly positions inside the deque, some past its end, some anywhere.
    function automatic logic [POS_W-1:0] pick_position(int held);
        int r;
        r = $urandom_range(0, 99);
        if (held == 0 && r < 40) return '0;
        if (r < 80 && held > 0) return POS_W'($urandom_range(0, held - 1));
        if (r < 90 && held < DEQ_CAPACITY) return POS_W'($urandom_range(held, POS_LAST));
        return POS_W'($urandom_range(0, POS_LAST));
    endfunction

    function automatic logic [OP_W-1:0] pick_op(phase_t phase);
        int r;
        r = $urandom_range(0, 99);
        case (phase)
            PH_GROW: begin
                if (r < 25) return OP_PUSH_FRONT;
                if (r < 50) return OP_PUSH_BACK;
                if (r < 72) return OP_INSERT;
                if (r < 80) return OP_READ;
                if (r < 87) return OP_WRITE;
                if (r < 92) return OP_REMOVE;
                if (r < 96) return OP_POP_FRONT;
                return OP_POP_BACK;
            end
            PH_SHRINK: begin
                if (r < 22) return OP_POP_FRONT;
                if (r < 44) return OP_POP_BACK;
                if (r < 66) return OP_REMOVE;
                if (r < 74) return OP_READ;
                if (r < 80) return OP_WRITE;
                if (r < 88) return OP_PUSH_FRONT;
                if (r < 94) return OP_PUSH_BACK;
                return OP_INSERT;
            end
            PH_FILL: begin
                if (r < 40) return OP_PUSH_BACK;
                if (r < 75) return OP_PUSH_FRONT;
                if (r < 90) return OP_INSERT;
                return OP_READ;
            end
            default: begin
                if (r < 3) return OP_CLEAR;
                if (r < 7) return OP_W'($urandom_range(OP_CLEAR + 1, OP_LAST_CODE));
                return OP_W'($urandom_range(OP_PUSH_FRONT, OP_WRITE));
            end
        endcase
    endfunction

    // Offers one request from a falling edge and returns at the falling edge
    // after it was taken.
    task automatic send_req(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic [VALUE_W-1:0] val);
        logic [S_TDATA_W-1:0] word;
        int                   gap;
        word = '0;
        word[S_FIELDS_W-1:0] = {val, pos, op};
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        requests_sent++;
    endtask

    // Result sink: random stalls counted in cycles, ready bursts, and one long
    // hold-off so that the core backs up and stops taking requests.
    initial begin : result_sink
        int stall_left;
        int eager_left;
        int r;
        stall_left = 0;
        eager_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!sink_pressure_done && results_seen >= 40) begin
                sink_pressure_done = 1'b1;
                stall_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else if (eager_left > 0) begin
                eager_left--;
                m_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    eager_left = $urandom_range(20, 80);
                    m_tready <= 1'b1;
                end else if (r < 60) begin
                    m_tready <= 1'b1;
                end else if (r < 95) begin
                    stall_left = $urandom_range(0, 3);
                    m_tready <= 1'b0;
                end else begin
                    stall_left = $urandom_range(10, 40);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    initial begin : stimulus
        phase_t phase;
        int     phase_no;
        int     len;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: all but push and clear on an empty deque, then the edges of
        // insert, remove, read and write, extreme words and unknown codes.
        send_req(OP_POP_FRONT,  '0, '0);
        send_req(OP_POP_BACK,   '0, '0);
        send_req(OP_REMOVE,     '0, '0);
        send_req(OP_READ,       '0, '0);
        send_req(OP_WRITE,      '0, WORD_ONES);
        send_req(OP_INSERT,     8'd1, WORD_MAX);
        send_req(OP_INSERT,     '0, WORD_MIN);
        send_req(OP_PUSH_FRONT, POS_LAST, WORD_MAX);
        send_req(OP_PUSH_BACK,  POS_LAST, WORD_ONES);
        send_req(OP_INSERT,     8'd1, '0);
        send_req(OP_READ,       8'd3, '0);
        send_req(OP_READ,       8'd4, '0);
        send_req(OP_READ,       POS_LAST, '0);
        send_req(OP_WRITE,      8'd2, 32'h1234_5678);
        send_req(OP_WRITE,      8'd4, WORD_MIN);
        send_req(OP_REMOVE,     8'd4, '0);
        send_req(OP_REMOVE,     8'd1, '0);
        send_req(OP_INSERT,     8'd3, WORD_MAX);
        send_req(OP_POP_FRONT,  '0, '0);
        send_req(OP_POP_BACK,   '0, '0);
        send_req(OP_CLEAR + 4'd1, POS_LAST, WORD_ONES);
        send_req(OP_LAST_CODE,  POS_LAST, WORD_ONES);
        send_req(OP_CLEAR,      '0, '0);
        send_req(OP_PUSH_BACK,  '0, 32'h0BAD_F00D);
        send_req(OP_READ,       '0, '0);

        // Random phases; the second one always fills the deque to capacity
        // and then tries pushes and inserts against the full store.
        phase_no = 0;
        while (requests_sent < ITEM_TARGET) begin
            if (phase_no == 1 || (phase_no > 1 && $urandom_range(0, 9) == 0))
                phase = PH_FILL;
            else
                phase = phase_t'($urandom_range(PH_GROW, PH_MIXED));
            if (phase == PH_FILL) begin
                while (fill_level < DEQ_CAPACITY && requests_sent < ITEM_TARGET)
                    send_req(pick_op(PH_FILL), pick_position(fill_level), pick_word());
                repeat (6)
                    send_req(pick_op(PH_FILL), POS_W'($urandom_range(0, POS_LAST)),
                             pick_word());
            end else begin
                len = $urandom_range(20, 80);
                repeat (len)
                    send_req(pick_op(phase), pick_position(fill_level), pick_word());
            end
            phase_no++;
        end
        s_tvalid <= 1'b0;

        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Sent %0d requests over all operations and unknown codes; %0d results compared.",
                 requests_sent, results_seen);
        $display("Peak fill %0d of %0d, %0d requests refused as full, %0d mismatches.",
                 peak_fill, DEQ_CAPACITY, full_seen, mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/deq_pkg.sv
hdl/deq_ram.sv
hdl/bounded_deque_with_indexed_access_core.sv
tb/deque_result_checker.sv
tb/tb_top.sv
